@@ design/vigenere_byte_cipher_triangular_offset_core_assert.svh @@
// Assertion macros for the cipher core.
// Each check is sampled on the rising clock edge and is held off during reset.
`ifndef VIGENERE_BYTE_CIPHER_TRIANGULAR_OFFSET_CORE_ASSERT_SVH
`define VIGENERE_BYTE_CIPHER_TRIANGULAR_OFFSET_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define VBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/vbc_pkg.sv @@
package vbc_pkg;

	localparam int KEY_BYTES  = 32;
	localparam int KEY_WORDS  = KEY_BYTES / 8;
	localparam int KIDX_W     = $clog2(KEY_BYTES);
	localparam int LEN_W      = KIDX_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int KEYLEN_W   = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_WORD_0   = 3'd0,
		CFG_KEY_WORD_1   = 3'd1,
		CFG_KEY_WORD_2   = 3'd2,
		CFG_KEY_WORD_3   = 3'd3,
		CFG_KEY_LENGTH   = 3'd4,
		CFG_ENCRYPT_MODE = 3'd5
	} cfg_idx_t;

	// Settings seen by the datapath.
	typedef struct packed {
		logic [KEY_BYTES-1:0][7:0] key;
		logic [LEN_W-1:0]          len;     // effective cycle length, 1..KEY_BYTES
		logic                      encrypt;
	} cfg_t;

endpackage

@@ design/vbc_in_if.sv @@
interface vbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

@@ design/vbc_out_if.sv @@
interface vbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink   (input valid, input result_byte, output ready);
endinterface

@@ design/vbc_cfg_regs.sv @@
module vbc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output vbc_pkg::cfg_t                    cfg
);

	logic [vbc_pkg::KEY_WORDS-1:0][vbc_pkg::CFG_DATA_W-1:0] key_q;
	logic [vbc_pkg::KEYLEN_W-1:0]                           key_length_q;
	logic                                                   encrypt_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q          <= '0;
			key_length_q   <= vbc_pkg::KEYLEN_W'(1);
			encrypt_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (vbc_pkg::cfg_idx_t'(cfg_index))
				vbc_pkg::CFG_KEY_WORD_0:   key_q[0] <= cfg_data;
				vbc_pkg::CFG_KEY_WORD_1:   key_q[1] <= cfg_data;
				vbc_pkg::CFG_KEY_WORD_2:   key_q[2] <= cfg_data;
				vbc_pkg::CFG_KEY_WORD_3:   key_q[3] <= cfg_data;
				vbc_pkg::CFG_KEY_LENGTH:   key_length_q <= cfg_data[vbc_pkg::KEYLEN_W-1:0];
				vbc_pkg::CFG_ENCRYPT_MODE: encrypt_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Length zero acts as one, anything past the key store saturates.
	always_comb begin
		cfg.key     = key_q;
		cfg.encrypt = encrypt_mode_q;
		if (key_length_q == '0)
			cfg.len = vbc_pkg::LEN_W'(1);
		else if (32'(key_length_q) > vbc_pkg::KEY_BYTES)
			cfg.len = vbc_pkg::LEN_W'(vbc_pkg::KEY_BYTES);
		else
			cfg.len = vbc_pkg::LEN_W'(key_length_q);
	end

endmodule

@@ design/vbc_datapath.sv @@
`include "vigenere_byte_cipher_triangular_offset_core_assert.svh"

module vbc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  vbc_pkg::cfg_t cfg,
	vbc_in_if.sink        din,
	vbc_out_if.source     dout
);

	logic [7:0]                  pos_q;
	logic [7:0]                  tri_q;
	logic [vbc_pkg::KIDX_W-1:0]  ki_q;
	logic                        out_valid_q;
	logic [7:0]                  result_q;

	logic                        acc;
	logic [7:0]                  pos_base, tri_base, n, tri_nxt, off, kb, res;
	logic [vbc_pkg::KIDX_W-1:0]  ki_base, ki_cur, ki_nxt;
	logic [vbc_pkg::LEN_W-1:0]   ki_inc;

	// Output register frees as soon as the sink takes it.
	assign din.ready = !out_valid_q || dout.ready;
	assign acc       = din.valid && din.ready;

	always_comb begin
		pos_base = din.restart ? 8'd0 : pos_q;
		tri_base = din.restart ? 8'd0 : tri_q;
		ki_base  = din.restart ? '0 : ki_q;

		n       = pos_base + 8'd1;
		tri_nxt = tri_base + n;
		off     = n[0] ? tri_nxt : 8'(8'd0 - tri_nxt);

		// index past a shrunk length restarts the key cycle
		ki_cur = ({1'b0, ki_base} >= cfg.len) ? '0 : ki_base;
		kb     = cfg.key[ki_cur];
		ki_inc = {1'b0, ki_cur} + vbc_pkg::LEN_W'(1);
		ki_nxt = (ki_inc >= cfg.len) ? '0 : ki_inc[vbc_pkg::KIDX_W-1:0];

		res = cfg.encrypt ? 8'(din.data_byte + kb + off) : 8'(din.data_byte - kb - off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			tri_q       <= '0;
			ki_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= n;
				tri_q <= tri_nxt;
				ki_q  <= ki_nxt;
			end
			if (acc)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			result_q <= res;
	end

	assign dout.valid       = out_valid_q;
	assign dout.result_byte = result_q;

	`VBC_ASSERT_NXT(a_acc_gives_out, clk, arst_n, acc, out_valid_q, "accepted byte not presented")
	`VBC_ASSERT_IMP(a_empty_ready, clk, arst_n, !out_valid_q, din.ready, "empty stage not ready")
	`VBC_ASSERT_NXT(a_restart_pos, clk, arst_n, acc && din.restart, pos_q == 8'd1, "restart position")
	`VBC_ASSERT_NXT(a_tri_step, clk, arst_n, acc && !din.restart,
		tri_q == 8'($past(tri_q) + $past(pos_q) + 8'd1), "triangle sum step")

endmodule

@@ design/vigenere_byte_cipher_triangular_offset_core.sv @@
// Byte stream cipher: extended Vigenere over 256 values with an alternating
// triangular offset. Byte n of a message (from 1) becomes
// data + key[k] + T(n) mod 256 in encrypt mode, data - key[k] - T(n) in
// decrypt mode, with T(n) = n(n+1)/2 negated on even n; the key cycles over
// the configured length.
// Channels: din carries data_byte and restart (restart marks byte 1 of a new
// message); dout carries result_byte. A transaction happens on a clock edge
// with valid and ready both high. The cfg port writes key words, key length
// and mode; write only while no transaction is in flight.
// The result is registered and appears on dout in the cycle after its input transaction.
// Throughput: one byte per cycle while dout is ready, limited by the single
// output register; the position, triangle sum and key index update in that same cycle.
// Reset (arst_n low, async): key cleared, key length 1, encrypt mode, message
// state at "before position 1", output register empty.
// Stall: while dout is held with ready low, din.ready drops and the pending
// result stays put; a new byte is taken in the cycle the old result leaves.
module vigenere_byte_cipher_triangular_offset_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	vbc_in_if.sink                          din,
	vbc_out_if.source                       dout
);

	// Current key, effective length and mode.
	vbc_pkg::cfg_t cfg;

	vbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Message state, byte transform and output register.
	vbc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.din    (din),
		.dout   (dout)
	);

endmodule
